// ===== design/vmdma_pkg.sv =====
// Package: shared types and constants of the video-memory DMA controller.
`default_nettype none

package vmdma_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_HBLANK = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    // Copy engine modes
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_BLOCK   = 2'd1,
        MODE_GENERAL = 2'd2
    } mode_t;

    // Register indexes
    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_CTRL   = 3'd4;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned REM_W       = 12;

    localparam logic [REM_W-1:0] BLOCK_COUNT = REM_W'(BLOCK_BYTES);
    localparam logic [6:0]       LEN_RESET   = 7'h7F;
    localparam logic [7:0]       READ_IDLE   = 8'hFF;
    localparam logic [2:0]       VRAM_TOP    = 3'b100;

    typedef struct packed {
        op_t        operation;
        logic [2:0] reg_index;
        logic [7:0] write_value;
        logic       in_hblank;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_value;
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [15:0] copy_target;
        logic        busy_res;
    } result_t;

endpackage

`default_nettype wire

// ===== design/vmdma_engine.sv =====
// Engine: register file, copy mode state machine and per-item result logic.
`default_nettype none

module vmdma_engine
    import vmdma_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire item_t   item,
    output result_t      result
);

    mode_t              mode_reg, mode_next;
    logic [15:0]        src_reg, src_next;
    logic [15:0]        dst_reg, dst_next;
    logic [6:0]         len_reg, len_next;
    logic               blank_reg, blank_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic               busy;
    logic [15:0]        src_inc;
    logic [15:0]        dst_inc;
    logic [REM_W-1:0]   rem_dec;
    logic [6:0]         len_dec;
    logic [7:0]         len_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            src_reg   <= '0;
            dst_reg   <= '0;
            len_reg   <= LEN_RESET;
            blank_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            len_reg   <= len_next;
            blank_reg <= blank_next;
            rem_reg   <= rem_next;
        end
    end

    assign src_inc  = src_reg + 16'd1;
    assign dst_inc  = dst_reg + 16'd1;
    assign rem_dec  = (rem_reg != '0) ? rem_reg - REM_W'(1) : rem_reg;
    assign len_dec  = len_reg - 7'd1;
    assign len_plus = {1'b0, item.write_value[6:0]} + 8'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        blank_next = blank_reg;
        rem_next   = rem_reg;

        result.read_value  = '0;
        result.copy_valid  = 1'b0;
        result.copy_source = '0;
        result.copy_target = '0;

        case (mode_reg)
            MODE_BLOCK, MODE_GENERAL: busy = 1'b1;
            default:                  busy = 1'b0;
        endcase

        // Unused mode code falls back to idle
        if (!busy)
        begin
            mode_next = MODE_IDLE;
        end

        case (item.operation)
            OP_WRITE:
            begin
                if (!busy)
                begin
                    case (item.reg_index)
                        REG_SRC_HI: src_next = {item.write_value, src_reg[7:4], 4'h0};
                        REG_SRC_LO: src_next = {src_reg[15:8], item.write_value[7:4], 4'h0};
                        REG_DST_HI: dst_next = {item.write_value, dst_reg[7:4], 4'h0};
                        REG_DST_LO: dst_next = {dst_reg[15:8], item.write_value[7:4], 4'h0};
                        REG_CTRL:
                        begin
                            len_next = item.write_value[6:0];
                            if (item.write_value[7])
                            begin
                                blank_next = 1'b1;
                                if (item.in_hblank)
                                begin
                                    mode_next = MODE_BLOCK;
                                    rem_next  = BLOCK_COUNT;
                                end
                            end
                            else if (blank_reg)
                            begin
                                blank_next = 1'b0;
                            end
                            else
                            begin
                                mode_next = MODE_GENERAL;
                                rem_next  = {len_plus, 4'h0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_READ:
            begin
                if (item.reg_index == REG_CTRL)
                begin
                    result.read_value = {~blank_reg, len_reg};
                end
                else
                begin
                    result.read_value = READ_IDLE;
                end
            end
            OP_HBLANK:
            begin
                if (blank_reg && !busy)
                begin
                    mode_next = MODE_BLOCK;
                    rem_next  = BLOCK_COUNT;
                end
            end
            default:
            begin
                if (busy)
                begin
                    result.copy_valid  = 1'b1;
                    result.copy_source = src_reg;
                    result.copy_target = {VRAM_TOP, dst_reg[12:0]};
                    src_next = src_inc;
                    dst_next = dst_inc;
                    rem_next = rem_dec;
                    // End of block or copy: count runs out or destination wraps
                    if (rem_dec == '0 || dst_inc == '0)
                    begin
                        if (mode_reg == MODE_BLOCK)
                        begin
                            len_next = len_dec;
                            if (len_dec == LEN_RESET || dst_inc == '0)
                            begin
                                blank_next = 1'b0;
                            end
                        end
                        else
                        begin
                            len_next = rem_dec[10:4] - 7'd1;
                        end
                        mode_next = MODE_IDLE;
                        rem_next  = '0;
                    end
                end
            end
        endcase

        case (mode_next)
            MODE_BLOCK, MODE_GENERAL: result.busy_res = 1'b1;
            default:                  result.busy_res = 1'b0;
        endcase
    end

    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_IDLE |-> rem_reg == '0)
        else $error("idle engine holds a nonzero byte count");

    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_IDLE |-> rem_reg != '0)
        else $error("busy engine with zero byte count");

    a_block_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_BLOCK |-> rem_reg <= BLOCK_COUNT)
        else $error("block count exceeds block size");

    a_copy_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.copy_valid |-> busy && item.operation == OP_TICK)
        else $error("copy requested while idle");

endmodule

`default_nettype wire

// ===== design/video_memory_dma_controller.sv =====
// Top level: item input register, engine and result register with handshake.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_stall      operation, reg_index, write_value, in_hblank
//   result   out        result_valid / result_stall  read_value, copy_valid, copy_source,
//                                                    copy_target, busy_res
//
// An accepted item is held in the input register; the engine computes its result and the
// result register captures it when the item advances, after which the result is offered.
// One item per cycle is sustained while result_stall stays low; the engine state updates once per item.
// Reset (rst_n low, asynchronous) empties both registers, zeroes the addresses, sets length
// to 0x7F and idles the engine.
// A stalled result holds the result register; an empty input register still takes one item.
`default_nettype none

module video_memory_dma_controller
    import vmdma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [2:0]  reg_index,
    input  wire logic [7:0]  write_value,
    input  wire logic        in_hblank,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       read_value,
    output logic             copy_valid,
    output logic [15:0]      copy_source,
    output logic [15:0]      copy_target,
    output logic             busy_res
);

    logic    item_valid_reg, item_valid_next;
    item_t   item_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;
    result_t result_comb;
    logic    accept;
    logic    advance;

    // Move the held item into the result register whenever that slot frees up
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Capture the item payload only on acceptance and the result only on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation   <= op_t'(operation);
            item_reg.reg_index   <= reg_index;
            item_reg.write_value <= write_value;
            item_reg.in_hblank   <= in_hblank;
        end
        if (advance)
        begin
            result_reg <= result_comb;
        end
    end

    vmdma_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (result_comb)
    );

    assign result_valid = result_valid_reg;
    assign read_value   = result_reg.read_value;
    assign copy_valid   = result_reg.copy_valid;
    assign copy_source  = result_reg.copy_source;
    assign copy_target  = result_reg.copy_target;
    assign busy_res     = result_reg.busy_res;

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_valid_reg && result_valid_reg && result_stall)
        else $error("input stalled with room downstream");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced item did not reach result register");

endmodule

`default_nettype wire

// ===== test/tb_video_memory_dma_controller.sv =====
`timescale 1ns / 100ps
// Testbench for the video-memory DMA controller: items checked against a predictor.
module tb_video_memory_dma_controller;
    import vmdma_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int MAX_IDLE     = 19;
    localparam int DRAIN_CYCLES = 10;
    localparam int CALM_PERIOD  = 40;

    // DUT ports; every input holds a known value from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [1:0]  operation    = '0;
    logic [2:0]  reg_index    = '0;
    logic [7:0]  write_value  = '0;
    logic        in_hblank    = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  read_value;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_target;
    logic        busy_res;

    // Items waiting to be driven and results waiting to be seen
    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   driven_item;
    result_t oldest_result;

    // Predictor copy of the engine state
    logic [15:0]      src_addr    = '0;
    logic [15:0]      dst_addr    = '0;
    logic [6:0]       len_field   = LEN_RESET;
    logic             blank_armed = 1'b0;
    mode_t            engine_mode = MODE_IDLE;
    logic [REM_W-1:0] bytes_left  = '0;

    // Bookkeeping
    int items_queued   = 0;
    int items_sent     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int errors         = 0;
    int reads_done     = 0;
    int bytes_copied   = 0;
    int blocks_done    = 0;
    int generals_done  = 0;
    int tx_wait        = 0;
    int rx_wait        = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    video_memory_dma_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .reg_index    (reg_index),
        .write_value  (write_value),
        .in_hblank    (in_hblank),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_value   (read_value),
        .copy_valid   (copy_valid),
        .copy_source  (copy_source),
        .copy_target  (copy_target),
        .busy_res     (busy_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the predictor by one accepted item and queue the result it causes.
    task automatic predict_dma_result(input item_t it);
        result_t r;
        logic    busy;
        r    = '0;
        busy = (engine_mode != MODE_IDLE);
        case (it.operation)
            OP_WRITE:
            begin
                // every register write is dropped while a copy runs
                if (!busy)
                begin
                    case (it.reg_index)
                        REG_SRC_HI: src_addr = {it.write_value, src_addr[7:4], 4'h0};
                        REG_SRC_LO: src_addr = {src_addr[15:8], it.write_value[7:4], 4'h0};
                        REG_DST_HI: dst_addr = {it.write_value, dst_addr[7:4], 4'h0};
                        REG_DST_LO: dst_addr = {dst_addr[15:8], it.write_value[7:4], 4'h0};
                        REG_CTRL:
                        begin
                            len_field = it.write_value[6:0];
                            if (it.write_value[7])
                            begin
                                // arm blank mode; start a block at once if already in blank
                                blank_armed = 1'b1;
                                if (it.in_hblank)
                                begin
                                    engine_mode = MODE_BLOCK;
                                    bytes_left  = BLOCK_COUNT;
                                end
                            end
                            else if (blank_armed)
                            begin
                                blank_armed = 1'b0;
                            end
                            else
                            begin
                                engine_mode = MODE_GENERAL;
                                bytes_left  = REM_W'((int'(len_field) + 1) * BLOCK_BYTES);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_READ:
            begin
                reads_done++;
                r.read_value = (it.reg_index == REG_CTRL) ? {~blank_armed, len_field}
                                                           : READ_IDLE;
            end
            OP_HBLANK:
            begin
                if (blank_armed && !busy)
                begin
                    engine_mode = MODE_BLOCK;
                    bytes_left  = BLOCK_COUNT;
                end
            end
            OP_TICK:
            begin
                if (busy)
                begin
                    bytes_copied++;
                    r.copy_valid  = 1'b1;
                    r.copy_source = src_addr;
                    r.copy_target = {VRAM_TOP, dst_addr[12:0]};
                    src_addr      = src_addr + 16'd1;
                    dst_addr      = dst_addr + 16'd1;
                    if (bytes_left != '0)
                        bytes_left = bytes_left - 1'b1;
                    // end of copy: count exhausted or destination wrapped to zero
                    if (bytes_left == '0 || dst_addr == 16'h0000)
                    begin
                        if (engine_mode == MODE_BLOCK)
                        begin
                            blocks_done++;
                            len_field = len_field - 7'd1;
                            if (len_field == LEN_RESET || dst_addr == 16'h0000)
                                blank_armed = 1'b0;
                        end
                        else
                        begin
                            generals_done++;
                            len_field = 7'(bytes_left[REM_W-1:4] - 1'b1);
                        end
                        engine_mode = MODE_IDLE;
                        bytes_left  = '0;
                    end
                end
            end
            default: ;
        endcase
        r.busy_res = (engine_mode != MODE_IDLE);
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Driver: hold a stalled item, otherwise wait out the drawn gap and present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            operation   <= '0;
            reg_index   <= '0;
            write_value <= '0;
            in_hblank   <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_dma_result(driven_item);
                items_accepted++;
            end
            if (!(item_valid && item_stall))
            begin
                if (tx_wait != 0)
                begin
                    tx_wait--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    driven_item = pending_items.pop_front();
                    operation   <= driven_item.operation;
                    reg_index   <= driven_item.reg_index;
                    write_value <= driven_item.write_value;
                    in_hblank   <= driven_item.in_hblank;
                    item_valid  <= 1'b1;
                    items_sent++;
                    // switch between gapped stretches and back-to-back stretches
                    if (items_sent % CALM_PERIOD == 0)
                        tx_calm = ($urandom_range(0, 3) == 0);
                    tx_wait = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation, then draw a stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, {read_value, copy_valid, copy_source, copy_target, busy_res});
                    errors++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("read_value", 16'(oldest_result.read_value), 16'(read_value));
                    check_field("copy_valid", 16'(oldest_result.copy_valid), 16'(copy_valid));
                    check_field("copy_source", oldest_result.copy_source, copy_source);
                    check_field("copy_target", oldest_result.copy_target, copy_target);
                    check_field("busy_res", 16'(oldest_result.busy_res), 16'(busy_res));
                end
                results_seen++;
                if (results_seen % CALM_PERIOD == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic add_item(input op_t op, input logic [2:0] idx, input logic [7:0] v,
                            input logic hb);
        item_t it;
        it.operation   = op;
        it.reg_index   = idx;
        it.write_value = v;
        it.in_hblank   = hb;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Ticks with the odd read, dropped write or stray blank event mixed in.
    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 15))
                0: add_item(OP_READ, REG_CTRL, 8'($urandom), 1'($urandom));
                1: add_item(OP_WRITE, 3'($urandom), 8'($urandom), 1'($urandom));
                2: add_item(OP_HBLANK, 3'($urandom), 8'($urandom), 1'($urandom));
                default: ;
            endcase
            add_item(OP_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // One well-formed transfer: addresses, control, then blank events and ticks.
    task automatic add_transfer();
        logic [7:0]  src_hi, src_lo, dst_hi, dst_lo;
        logic [6:0]  len;
        logic        blank, hb;
        int unsigned dst_start, to_wrap, span, blocks;
        src_hi = 8'($urandom);
        src_lo = 8'($urandom);
        dst_hi = 8'($urandom);
        dst_lo = 8'($urandom);
        blank  = 1'($urandom);
        hb     = 1'($urandom);
        // most lengths are short; the longest runs sit near the top so they wrap early
        len    = ($urandom_range(0, 11) == 0) ? LEN_RESET : 7'($urandom_range(0, 3));
        if (len == LEN_RESET || $urandom_range(0, 7) == 0)
            dst_hi = 8'hFF;
        if ($urandom_range(0, 1) == 0)
        begin
            add_item(OP_WRITE, REG_SRC_HI, src_hi, 1'($urandom));
            add_item(OP_WRITE, REG_SRC_LO, src_lo, 1'($urandom));
            add_item(OP_WRITE, REG_DST_HI, dst_hi, 1'($urandom));
            add_item(OP_WRITE, REG_DST_LO, dst_lo, 1'($urandom));
        end
        else
        begin
            add_item(OP_WRITE, REG_DST_LO, dst_lo, 1'($urandom));
            add_item(OP_WRITE, REG_SRC_LO, src_lo, 1'($urandom));
            add_item(OP_WRITE, REG_DST_HI, dst_hi, 1'($urandom));
            add_item(OP_WRITE, REG_SRC_HI, src_hi, 1'($urandom));
        end
        dst_start = 32'({dst_hi, dst_lo[7:4], 4'h0});
        to_wrap   = 32'h10000 - dst_start;
        add_item(OP_WRITE, REG_CTRL, {blank, len}, hb);
        if (!blank)
        begin
            span = (int'(len) + 1) * BLOCK_BYTES;
            add_ticks((span < to_wrap) ? span : to_wrap);
        end
        else
        begin
            blocks = (len == LEN_RESET) ? $urandom_range(2, 3) : int'(len) + 1;
            for (int b = 0; b < blocks; b++)
            begin
                if (!(b == 0 && hb))
                    add_item(OP_HBLANK, 3'($urandom), 8'($urandom), 1'($urandom));
                add_ticks(BLOCK_BYTES);
                // cancel an armed transfer between blocks now and then
                if (len == LEN_RESET && b == blocks - 1 ||
                    len != 7'd0 && b == 0 && $urandom_range(0, 4) == 0)
                begin
                    add_item(OP_WRITE, REG_CTRL, {1'b0, 7'($urandom_range(0, 3))}, 1'($urandom));
                    break;
                end
            end
        end
        add_item(OP_READ, REG_CTRL, 8'($urandom), 1'($urandom));
    endtask

    // Random items; control writes keep short lengths so they do not swamp the run.
    task automatic add_noise(input int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it = item_t'($urandom);
            if (it.operation == OP_WRITE && it.reg_index == REG_CTRL)
                it.write_value[6:0] = 7'($urandom_range(0, 3));
            add_item(it.operation, it.reg_index, it.write_value, it.in_hblank);
        end
    endtask

    initial
    begin
        // Directed opening: reset status, unmapped and write-only reads, dropped writes.
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);
        add_item(OP_READ, REG_SRC_HI, 8'h00, 1'b0);
        add_item(OP_READ, 3'd7, 8'h00, 1'b0);
        add_item(OP_WRITE, 3'd5, 8'hFF, 1'b1);
        add_item(OP_TICK, 3'd0, 8'h00, 1'b0);
        add_item(OP_HBLANK, 3'd0, 8'h00, 1'b1);
        // low nibble forced to zero; high write keeps bits 7..4 of the low byte
        add_item(OP_WRITE, REG_SRC_LO, 8'hFF, 1'b0);
        add_item(OP_WRITE, REG_SRC_HI, 8'hFF, 1'b0);
        add_item(OP_WRITE, REG_DST_LO, 8'hFF, 1'b0);
        add_item(OP_WRITE, REG_DST_HI, 8'h9F, 1'b0);
        // arm while already in blank: one block starts at once with length zero
        add_item(OP_WRITE, REG_CTRL, 8'h80, 1'b1);
        add_item(OP_WRITE, REG_SRC_HI, 8'h00, 1'b0);
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);
        add_item(OP_HBLANK, 3'd0, 8'h00, 1'b0);
        // source runs up to 0xFFFF and wraps at the block end; the block end takes length to 0x7F and disarms
        for (int i = 0; i < BLOCK_BYTES; i++)
            add_item(OP_TICK, 3'd0, 8'h00, 1'b0);
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);
        // arm outside blank, then cancel with a clear bit 7
        add_item(OP_WRITE, REG_CTRL, 8'h85, 1'b0);
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);
        add_item(OP_WRITE, REG_CTRL, 8'h00, 1'b0);
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);
        // general copy of two blocks cut short by the destination wrapping to zero
        add_item(OP_WRITE, REG_DST_LO, 8'hF0, 1'b0);
        add_item(OP_WRITE, REG_DST_HI, 8'hFF, 1'b0);
        add_item(OP_WRITE, REG_CTRL, 8'h01, 1'b0);
        for (int i = 0; i < BLOCK_BYTES + 1; i++)
            add_item(OP_TICK, 3'd0, 8'h00, 1'b0);
        add_item(OP_READ, REG_CTRL, 8'h00, 1'b0);

        // Random part: mostly well-formed transfers, some noise.
        while (items_queued < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 8)
                add_transfer();
            else
                add_noise($urandom_range(4, 12));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every item accepted, every result seen, then a short quiet spell.
        while (items_accepted != items_queued)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d results: %0d reads, %0d bytes copied",
                 items_accepted, results_seen, reads_done, bytes_copied);
        $display("copies ended: %0d blank-mode blocks, %0d general transfers",
                 blocks_done, generals_done);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vmdma_pkg.sv
design/vmdma_engine.sv
design/video_memory_dma_controller.sv
test/tb_video_memory_dma_controller.sv
